### hdl/protobuf_nested_field_decoder_assert.svh
// Assertion macros used by the decoder core.
`ifndef PROTOBUF_NESTED_FIELD_DECODER_ASSERT_SVH
`define PROTOBUF_NESTED_FIELD_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define PNFD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define PNFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/pnfd_pkg.sv
// Types, codes and constants of the nested protobuf field decoder.
package pnfd_pkg;

    localparam int MAX_SECOND_GROUPS = 3;
    localparam int PNFD_OUT_DEPTH    = 4;
    localparam logic [11:0] LEN_MAX  = 12'hFFF;

    // configuration register indexes
    localparam logic [1:0] REG_HEADER_LENGTH = 2'd0;
    localparam logic [1:0] REG_FIRST_NESTED  = 2'd1;
    localparam logic [1:0] REG_SECOND_NESTED = 2'd2;
    localparam logic [1:0] REG_SECOND_LIMIT  = 2'd3;

    localparam logic [3:0] RST_HEADER_LENGTH = 4'd10;
    localparam logic [7:0] RST_FIRST_NESTED  = 8'd9;
    localparam logic [7:0] RST_SECOND_NESTED = 8'd11;
    localparam logic [1:0] RST_SECOND_LIMIT  = 2'd2;

    // wire types
    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_I64    = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_I32    = 3'd5;

    // nesting groups
    localparam logic [1:0] GRP_TOP    = 2'd0;
    localparam logic [1:0] GRP_FIRST  = 2'd1;
    localparam logic [1:0] GRP_SECOND = 2'd2;

    // frame status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TRUNC   = 2'd1;
    localparam logic [1:0] ST_OVERRUN = 2'd2;

    typedef enum logic [1:0] {
        PH_TAG,
        PH_VALUE,
        PH_LEN,
        PH_SKIP
    } phase_t;

    typedef struct packed {
        logic [3:0] header_length;
        logic [7:0] first_nested_field;
        logic [7:0] second_nested_field;
        logic [1:0] second_nested_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  nest_group;
        logic [1:0]  occurrence;
        logic [7:0]  field_number;
        logic [63:0] field_value;
        logic        is_frame_status;
        logic [1:0]  frame_status;
        logic        last;
    } res_t;

    typedef struct packed {
        logic field_vld;
        logic stat_vld;
        res_t field;
        res_t stat;
    } core_out_t;

    typedef struct packed {
        logic [1:0] cnt;
        res_t       a;
        res_t       b;
    } push_t;

endpackage

### hdl/pnfd_core.sv
// Byte-wide protobuf tag, varint and nesting parser.
`include "protobuf_nested_field_decoder_assert.svh"

module pnfd_core import pnfd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      in_accept,
    input  logic [7:0] in_byte,
    input  logic      in_end,
    output core_out_t res
);

    logic [3:0]  hdr_cnt_reg, hdr_cnt_next;
    phase_t      phase_reg, phase_next;
    logic [1:0]  inside_reg, inside_next;
    logic [63:0] acc_reg, acc_next;
    logic [6:0]  shift_reg, shift_next;
    logic [7:0]  fn_reg, fn_next;
    logic [2:0]  wt_reg, wt_next;
    logic [11:0] skip_reg, skip_next;
    logic [11:0] nest_reg, nest_next;
    logic [1:0]  sg_reg, sg_next;

    // parse result before the end-of-frame clear
    logic [3:0]  pn_hdr;
    phase_t      pn_phase;
    logic [1:0]  pn_inside;
    logic [63:0] pn_acc;
    logic [6:0]  pn_shift;
    logic [7:0]  pn_fn;
    logic [2:0]  pn_wt;
    logic [11:0] pn_skip;
    logic [11:0] pn_nest;
    logic [1:0]  pn_sg;

    logic        in_hdr;
    logic        was_nested;
    logic [63:0] acc_upd;
    logic        vdone;
    logic [11:0] len_sat;
    logic [1:0]  lim;
    logic [11:0] skip_dec;
    logic [11:0] nest_dec;
    logic [1:0]  occ;
    logic [1:0]  stat_code;

    assign in_hdr     = hdr_cnt_reg < cfg.header_length;
    assign was_nested = inside_reg != GRP_TOP;
    assign acc_upd    = acc_reg | ((shift_reg < 7'd64)
                        ? ({57'd0, in_byte[6:0]} << shift_reg[5:0]) : 64'd0);
    assign vdone      = !in_byte[7] && !in_hdr && phase_reg != PH_SKIP;
    assign len_sat    = (|acc_upd[63:12]) ? LEN_MAX : acc_upd[11:0];
    assign lim        = ({2'b00, cfg.second_nested_limit} < 4'(MAX_SECOND_GROUPS))
                        ? cfg.second_nested_limit : 2'(MAX_SECOND_GROUPS);
    assign skip_dec   = (skip_reg != 12'd0) ? skip_reg - 12'd1 : skip_reg;
    assign nest_dec   = (nest_reg != 12'd0) ? nest_reg - 12'd1 : nest_reg;
    assign occ        = (inside_reg == GRP_SECOND) ? sg_reg - 2'd1 : 2'd0;

    always_comb begin
        pn_hdr    = hdr_cnt_reg;
        pn_phase  = phase_reg;
        pn_inside = inside_reg;
        pn_acc    = acc_reg;
        pn_shift  = shift_reg;
        pn_fn     = fn_reg;
        pn_wt     = wt_reg;
        pn_skip   = skip_reg;
        pn_nest   = nest_reg;
        pn_sg     = sg_reg;
        if (in_hdr) begin
            pn_hdr = hdr_cnt_reg + 4'd1;
        end else begin
            if (phase_reg == PH_SKIP) begin
                pn_skip = skip_dec;
                if (skip_dec == 12'd0) pn_phase = PH_TAG;
            end else begin
                pn_acc = acc_upd;
                if (shift_reg < 7'd70) pn_shift = shift_reg + 7'd7;
                if (!in_byte[7]) begin
                    pn_acc   = 64'd0;
                    pn_shift = 7'd0;
                    case (phase_reg)
                        PH_TAG: begin
                            pn_fn = acc_upd[10:3];
                            pn_wt = acc_upd[2:0];
                            case (acc_upd[2:0])
                                WT_VARINT: pn_phase = PH_VALUE;
                                WT_LEN:    pn_phase = PH_LEN;
                                WT_I64: begin
                                    pn_phase = PH_SKIP;
                                    pn_skip  = 12'd8;
                                end
                                WT_I32: begin
                                    pn_phase = PH_SKIP;
                                    pn_skip  = 12'd4;
                                end
                                default:   pn_phase = PH_TAG;
                            endcase
                        end
                        PH_VALUE: pn_phase = PH_TAG;
                        default: begin
                            pn_phase = PH_TAG;
                            if (!was_nested && fn_reg == cfg.first_nested_field) begin
                                if (len_sat != 12'd0) begin
                                    pn_inside = GRP_FIRST;
                                    pn_nest   = len_sat;
                                end
                            end else if (!was_nested && fn_reg == cfg.second_nested_field
                                         && sg_reg < lim) begin
                                pn_sg = sg_reg + 2'd1;
                                if (len_sat != 12'd0) begin
                                    pn_inside = GRP_SECOND;
                                    pn_nest   = len_sat;
                                end
                            end else if (len_sat != 12'd0) begin
                                pn_phase = PH_SKIP;
                                pn_skip  = len_sat;
                            end
                        end
                    endcase
                end
            end
            // body end: drop any partial varint or skip and return to top level
            if (was_nested) begin
                pn_nest = nest_dec;
                if (nest_dec == 12'd0) begin
                    pn_inside = GRP_TOP;
                    pn_phase  = PH_TAG;
                    pn_acc    = 64'd0;
                    pn_shift  = 7'd0;
                    pn_skip   = 12'd0;
                end
            end
        end
    end

    always_comb begin
        hdr_cnt_next = pn_hdr;
        phase_next   = pn_phase;
        inside_next  = pn_inside;
        acc_next     = pn_acc;
        shift_next   = pn_shift;
        fn_next      = pn_fn;
        wt_next      = pn_wt;
        skip_next    = pn_skip;
        nest_next    = pn_nest;
        sg_next      = pn_sg;
        if (in_end) begin
            hdr_cnt_next = 4'd0;
            phase_next   = PH_TAG;
            inside_next  = GRP_TOP;
            acc_next     = 64'd0;
            shift_next   = 7'd0;
            fn_next      = 8'd0;
            wt_next      = 3'd0;
            skip_next    = 12'd0;
            nest_next    = 12'd0;
            sg_next      = 2'd0;
        end
    end

    always_comb begin
        if (pn_phase == PH_SKIP || pn_inside != GRP_TOP) begin
            stat_code = ST_OVERRUN;
        end else if (pn_phase == PH_VALUE || pn_phase == PH_LEN ||
                     (pn_phase == PH_TAG && pn_shift != 7'd0)) begin
            stat_code = ST_TRUNC;
        end else begin
            stat_code = ST_OK;
        end
        res.field_vld             = in_accept && vdone && phase_reg == PH_VALUE;
        res.field.nest_group      = inside_reg;
        res.field.occurrence      = occ;
        res.field.field_number    = fn_reg;
        res.field.field_value     = acc_upd;
        res.field.is_frame_status = 1'b0;
        res.field.frame_status    = ST_OK;
        res.field.last            = !in_end;
        res.stat_vld              = in_accept && in_end;
        res.stat.nest_group       = GRP_TOP;
        res.stat.occurrence       = 2'd0;
        res.stat.field_number     = 8'd0;
        res.stat.field_value      = 64'd0;
        res.stat.is_frame_status  = 1'b1;
        res.stat.frame_status     = stat_code;
        res.stat.last             = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_cnt_reg <= 4'd0;
            phase_reg   <= PH_TAG;
            inside_reg  <= GRP_TOP;
            acc_reg     <= 64'd0;
            shift_reg   <= 7'd0;
            fn_reg      <= 8'd0;
            wt_reg      <= 3'd0;
            skip_reg    <= 12'd0;
            nest_reg    <= 12'd0;
            sg_reg      <= 2'd0;
        end else if (in_accept) begin
            hdr_cnt_reg <= hdr_cnt_next;
            phase_reg   <= phase_next;
            inside_reg  <= inside_next;
            acc_reg     <= acc_next;
            shift_reg   <= shift_next;
            fn_reg      <= fn_next;
            wt_reg      <= wt_next;
            skip_reg    <= skip_next;
            nest_reg    <= nest_next;
            sg_reg      <= sg_next;
        end
    end

    `PNFD_ASSERT_NEXT(a_end_clears, aclk, aresetn, in_accept && in_end,
        hdr_cnt_reg == 4'd0 && inside_reg == GRP_TOP && sg_reg == 2'd0)
    `PNFD_ASSERT_IMPL(a_body_open, aclk, aresetn, inside_reg != GRP_TOP, nest_reg != 12'd0)
    `PNFD_ASSERT_IMPL(a_skip_open, aclk, aresetn, phase_reg == PH_SKIP, skip_reg != 12'd0)
    `PNFD_ASSERT_IMPL(a_second_counted, aclk, aresetn, inside_reg == GRP_SECOND,
        sg_reg != 2'd0)

endmodule

### hdl/pnfd_outq.sv
// Small result queue that parts the parser from the output channel.
module pnfd_outq import pnfd_pkg::*; #(
    parameter int DEPTH = PNFD_OUT_DEPTH
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  push_t push,
    input  logic  pop,
    output res_t  head,
    output logic  head_vld,
    output logic  room
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    res_t          mem [DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0] wr1;
    logic [PW-1:0] wr2;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + PW'(1));
    endfunction

    assign wr1 = wrap_inc(wr_reg);
    assign wr2 = wrap_inc(wr1);

    always_comb begin
        case (push.cnt)
            2'd1:    wr_next = wr1;
            2'd2:    wr_next = wr2;
            default: wr_next = wr_reg;
        endcase
        rd_next  = pop ? wrap_inc(rd_reg) : rd_reg;
        cnt_next = CW'(cnt_reg + CW'(push.cnt) - CW'(pop));
    end

    assign head     = mem[rd_reg];
    assign head_vld = cnt_reg != '0;
    // leave space for the two words a frame-ending byte can produce
    assign room     = cnt_reg <= CW'(DEPTH - 2);

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) mem[wr_reg] <= push.a;
        if (push.cnt == 2'd2) mem[wr1] <= push.b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### hdl/protobuf_nested_field_decoder.sv
// Protobuf varint field decoder with one level of nesting: one frame byte is taken on
// every clock cycle while s_tready is high. Each byte updates the parser state in the
// same cycle it is accepted, and its results go into a four-word output queue drained
// one word a cycle while m_tready is high; a byte that completes a varint and also ends
// the frame yields two words, a field word and a status word. The input is held off
// only while the queue holds more than DEPTH-2 words. Frame status words report OK,
// truncation or overrun, and fields from an overrun body are not withdrawn.
module protobuf_nested_field_decoder import pnfd_pkg::*; #(
    parameter int OUT_DEPTH = PNFD_OUT_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // frame_end
    output logic        m_tvalid,
    input  logic        m_tready,
    // nest_group[1:0], occurrence[3:2], field_number[11:4], field_value[75:12],
    // frame_status[77:76], zero pad[79:78]
    output logic [79:0] m_tdata,
    output logic        m_tuser,   // is_frame_status
    output logic        m_tlast,   // last
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t      cfg_reg;
    core_out_t core_res;
    push_t     push;
    res_t      head;
    logic      in_accept;
    logic      room;

    assign s_tready  = room;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_length       <= RST_HEADER_LENGTH;
            cfg_reg.first_nested_field  <= RST_FIRST_NESTED;
            cfg_reg.second_nested_field <= RST_SECOND_NESTED;
            cfg_reg.second_nested_limit <= RST_SECOND_LIMIT;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_HEADER_LENGTH: cfg_reg.header_length       <= cfg_data[3:0];
                REG_FIRST_NESTED:  cfg_reg.first_nested_field  <= cfg_data;
                REG_SECOND_NESTED: cfg_reg.second_nested_field <= cfg_data;
                REG_SECOND_LIMIT:  cfg_reg.second_nested_limit <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    pnfd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_end    (s_tlast),
        .res       (core_res)
    );

    // the field word, when present, goes ahead of the status word
    assign push.cnt = {1'b0, core_res.field_vld} + {1'b0, core_res.stat_vld};
    assign push.a   = core_res.field_vld ? core_res.field : core_res.stat;
    assign push.b   = core_res.stat;

    pnfd_outq #(
        .DEPTH (OUT_DEPTH)
    ) u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .pop      (m_tvalid && m_tready),
        .head     (head),
        .head_vld (m_tvalid),
        .room     (room)
    );

    assign m_tdata = {2'b00, head.frame_status, head.field_value, head.field_number,
                      head.occurrence, head.nest_group};
    assign m_tuser = head.is_frame_status;
    assign m_tlast = head.last;

endmodule
